### design/hcs_pkg.sv
`timescale 1ns / 1ps
package hcs_pkg;

    localparam int TAG_W      = 16;
    localparam int FLOW_W     = 6;
    localparam int ROUND_W    = 32;
    localparam int POS_W      = 4;            // log2 of slots per level and of slot depth
    localparam int FILL_W     = 5;
    localparam int SLOT_ID_W  = 6;            // {level, bank, index}
    localparam int SLOT_COUNT = 64;
    localparam int FLOW_COUNT = 64;
    localparam int STORE_AW   = SLOT_ID_W + POS_W;
    localparam int REL_AW     = 6;
    localparam int REL_DEPTH  = 64;
    localparam int REL_CNT_W  = 7;
    localparam int HELD_W     = 11;
    localparam int HELD_MAX   = 1024;
    localparam int ROUNDS_W   = 10;           // runaway search limit is 2**ROUNDS_W rounds
    localparam int WEIGHT_W   = 10;
    localparam int BURST_W    = 16;
    localparam int OUTCOME_W  = 3;

    localparam logic [OUTCOME_W-1:0] OC_STORED     = 3'd0;
    localparam logic [OUTCOME_W-1:0] OC_DROP_BURST = 3'd1;
    localparam logic [OUTCOME_W-1:0] OC_DROP_LEVEL = 3'd2;
    localparam logic [OUTCOME_W-1:0] OC_DEQUEUED   = 3'd3;
    localparam logic [OUTCOME_W-1:0] OC_EMPTY      = 3'd4;
    localparam logic [OUTCOME_W-1:0] OC_DROP_FULL  = 3'd5;

    localparam logic MODE_ENQ = 1'b0;

    localparam logic [2:0] REG_BURST = 3'd0;
    localparam logic [2:0] REG_W0    = 3'd1;
    localparam logic [2:0] REG_W1    = 3'd2;
    localparam logic [2:0] REG_W2    = 3'd3;
    localparam logic [2:0] REG_W3    = 3'd4;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [POS_W-1:0]  head;
    } slot_meta_t;

    typedef struct packed {
        logic               sticky;
        logic [ROUND_W-1:0] last;
    } flow_entry_t;

    typedef logic [WEIGHT_W-1:0] weight_t;

endpackage

### design/hcs_ram.sv
`timescale 1ns / 1ps
module hcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/hierarchical_calendar_scheduler.sv
`timescale 1ns / 1ps
// Two-level calendar-queue packet scheduler, one item at a time. A stored
// enqueue (or a full-slot drop) steps through accept with flow table read,
// departure calc, level/slot pick with slot fill read, commit and result. A
// burst drop leaves after the departure calc and a level drop after the
// level pick. A dequeue with packets already on the release list pops one.
// Otherwise it serves rounds: each round reads the top-level slot fill, serves
// it, reads the low-level slot fill, serves it and closes the round, moving one
// packet a cycle out of the slot store into the release list; a search runs at
// most 1024 rounds. The input item is one s_ transfer; each item produces
// exactly one m_ transfer, held in an output register so the next item is
// taken while a result waits. All tables reset empty at once through valid
// bits; no clearing pass is needed.
module hierarchical_calendar_scheduler (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [23:0]              s_tdata,   // [5:0] flow_number, [21:6] packet_tag
    input  logic [0:0]               s_tuser,   // [0] mode
    // result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata,   // [15:0] released_tag
    output logic [2:0]               m_tuser,   // [2:0] outcome
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import hcs_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_E_READ   = 4'd1;
    localparam logic [3:0] ST_E_CALC   = 4'd2;
    localparam logic [3:0] ST_E_LEVEL  = 4'd3;
    localparam logic [3:0] ST_E_COMMIT = 4'd4;
    localparam logic [3:0] ST_D_START  = 4'd5;
    localparam logic [3:0] ST_META     = 4'd6;
    localparam logic [3:0] ST_SERVE    = 4'd7;
    localparam logic [3:0] ST_RND_END  = 4'd8;
    localparam logic [3:0] ST_POP      = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    localparam logic PH_TOP = 1'b0;
    localparam logic PH_LOW = 1'b1;

    // config registers
    logic [BURST_W-1:0] burst_limit_reg;
    weight_t            weight_reg [4];
    logic               cfg_wr;

    // control / datapath
    logic [3:0]             state_reg, state_next;
    logic [FLOW_W-1:0]      flow_reg, flow_next;
    logic [TAG_W-1:0]       tag_reg, tag_next;
    logic [ROUND_W-1:0]     round_now_reg, round_now_next;
    logic [HELD_W-1:0]      held_reg, held_next;
    logic [REL_AW-1:0]      rel_head_reg, rel_head_next;
    logic [REL_AW-1:0]      rel_tail_reg, rel_tail_next;
    logic [REL_CNT_W-1:0]   rel_count_reg, rel_count_next;
    logic [ROUND_W:0]       ahead_reg, ahead_next;
    logic [ROUND_W:0]       dep_reg, dep_next;
    logic                   sticky_reg, sticky_next;
    logic                   level_reg, level_next;
    logic [SLOT_ID_W-1:0]   slot_reg, slot_next;
    logic                   phase_reg, phase_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [POS_W-1:0]       head_reg, head_next;
    logic [FILL_W-1:0]      acc_reg, acc_next;
    logic [FILL_W-1:0]      take_reg, take_next;
    logic [FILL_W-1:0]      div_reg, div_next;
    logic [ROUNDS_W-1:0]    rounds_reg, rounds_next;
    logic                   pend_reg, pend_next;
    logic [OUTCOME_W-1:0]   res_oc_reg, res_oc_next;
    logic [TAG_W-1:0]       res_tag_reg, res_tag_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUTCOME_W-1:0]   m_oc_reg, m_oc_next;
    logic [TAG_W-1:0]       m_tag_reg, m_tag_next;

    // valid bits stand in for the zero reset of flow table and slot fills
    logic [FLOW_COUNT-1:0]  flow_vld_reg;
    logic [SLOT_COUNT-1:0]  meta_vld_reg;
    logic                   flow_rd_vld_reg;
    logic                   meta_rd_vld_reg;

    // memory ports
    logic                   flow_we, flow_re;
    logic [FLOW_W-1:0]      flow_raddr;
    flow_entry_t            flow_wdata;
    logic [ROUND_W:0]       flow_rdata;
    logic                   meta_we, meta_re;
    logic [SLOT_ID_W-1:0]   meta_waddr, meta_raddr;
    slot_meta_t             meta_wdata;
    logic [FILL_W+POS_W-1:0] meta_rdata;
    logic                   store_we, store_re;
    logic [STORE_AW-1:0]    store_waddr, store_raddr;
    logic [TAG_W-1:0]       store_rdata;
    logic                   rel_we, rel_re;
    logic [TAG_W-1:0]       rel_rdata;

    // combinational helpers
    flow_entry_t            flow_rd;
    slot_meta_t             meta_rd;
    logic [ROUND_W-1:0]     diff;
    logic [28:0]            dlt0;
    logic [24:0]            dlt1;
    logic                   lvl_hi;
    logic                   lvl_pick;
    logic                   bank_pick;
    logic [POS_W-1:0]       idx_pick;
    logic [ROUND_W-1:0]     round_inc;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_limit_reg <= BURST_W'(64);
            weight_reg[0]   <= WEIGHT_W'(1);
            weight_reg[1]   <= WEIGHT_W'(2);
            weight_reg[2]   <= WEIGHT_W'(4);
            weight_reg[3]   <= WEIGHT_W'(8);
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_BURST: burst_limit_reg <= pwdata[BURST_W-1:0];
                REG_W0:    weight_reg[0]   <= pwdata[WEIGHT_W-1:0];
                REG_W1:    weight_reg[1]   <= pwdata[WEIGHT_W-1:0];
                REG_W2:    weight_reg[2]   <= pwdata[WEIGHT_W-1:0];
                REG_W3:    weight_reg[3]   <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_BURST: prdata = {16'd0, burst_limit_reg};
            REG_W0:    prdata = {22'd0, weight_reg[0]};
            REG_W1:    prdata = {22'd0, weight_reg[1]};
            REG_W2:    prdata = {22'd0, weight_reg[2]};
            REG_W3:    prdata = {22'd0, weight_reg[3]};
            default:   prdata = 32'd0;
        endcase
    end

    // ---------------- memories ----------------
    // flow table: {sticky level, last departure round}
    hcs_ram #(.WIDTH(ROUND_W + 1), .DEPTH(FLOW_COUNT)) u_flow_ram (
        .aclk  (aclk),
        .we    (flow_we),
        .waddr (flow_reg),
        .wdata (flow_wdata),
        .re    (flow_re),
        .raddr (flow_raddr),
        .rdata (flow_rdata)
    );

    // per-slot fill count and circular head
    hcs_ram #(.WIDTH(FILL_W + POS_W), .DEPTH(SLOT_COUNT)) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    // packet tags, one row of slot depth per slot
    hcs_ram #(.WIDTH(TAG_W), .DEPTH(SLOT_COUNT * 16)) u_store_ram (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (tag_reg),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // release list, circular
    hcs_ram #(.WIDTH(TAG_W), .DEPTH(REL_DEPTH)) u_rel_ram (
        .aclk  (aclk),
        .we    (rel_we),
        .waddr (rel_tail_reg),
        .wdata (store_rdata),
        .re    (rel_re),
        .raddr (rel_head_reg),
        .rdata (rel_rdata)
    );

    assign flow_raddr = s_tdata[FLOW_W-1:0];
    assign flow_rd    = flow_rd_vld_reg ? flow_entry_t'(flow_rdata) : '0;
    assign meta_rd    = meta_rd_vld_reg ? slot_meta_t'(meta_rdata) : '0;

    // difference of last departure against the current round
    assign diff      = flow_rd.last - round_now_reg;
    assign dlt0      = dep_reg[ROUND_W:4] - {1'b0, round_now_reg[ROUND_W-1:4]};
    assign dlt1      = dep_reg[ROUND_W:8] - {1'b0, round_now_reg[ROUND_W-1:8]};
    assign lvl_hi    = dlt0 > 29'd1;
    // sticky promotion keeps the low-level index; top level has one bank
    assign lvl_pick  = lvl_hi | sticky_reg;
    assign idx_pick  = lvl_hi ? dep_reg[7:4] : dep_reg[3:0];
    assign bank_pick = lvl_pick ? 1'b0 : (lvl_hi ? dep_reg[8] : dep_reg[4]);
    assign round_inc = round_now_reg + ROUND_W'(1);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next     = state_reg;
        flow_next      = flow_reg;
        tag_next       = tag_reg;
        round_now_next = round_now_reg;
        held_next      = held_reg;
        rel_head_next  = rel_head_reg;
        rel_tail_next  = rel_tail_reg;
        rel_count_next = rel_count_reg;
        ahead_next     = ahead_reg;
        dep_next       = dep_reg;
        sticky_next    = sticky_reg;
        level_next     = level_reg;
        slot_next      = slot_reg;
        phase_next     = phase_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        acc_next       = acc_reg;
        take_next      = take_reg;
        div_next       = div_reg;
        rounds_next    = rounds_reg;
        pend_next      = 1'b0;
        res_oc_next    = res_oc_reg;
        res_tag_next   = res_tag_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_oc_next      = m_oc_reg;
        m_tag_next     = m_tag_reg;

        flow_we     = 1'b0;
        flow_re     = 1'b0;
        flow_wdata  = '{sticky: level_reg, last: dep_reg[ROUND_W-1:0]};
        meta_we     = 1'b0;
        meta_re     = 1'b0;
        meta_waddr  = slot_reg;
        meta_raddr  = slot_reg;
        meta_wdata  = '{fill: fill_reg - take_reg, head: head_reg + take_reg[POS_W-1:0]};
        store_we    = 1'b0;
        store_re    = 1'b0;
        store_waddr = {slot_reg, meta_rd.head + meta_rd.fill[POS_W-1:0]};
        store_raddr = {slot_reg, head_reg + take_reg[POS_W-1:0]};
        rel_we      = 1'b0;
        rel_re      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    flow_next    = s_tdata[FLOW_W-1:0];
                    tag_next     = s_tdata[FLOW_W +: TAG_W];
                    res_tag_next = '0;
                    if (s_tuser[0] == MODE_ENQ) begin
                        flow_re    = 1'b1;
                        state_next = ST_E_READ;
                    end else begin
                        state_next = ST_D_START;
                    end
                end
            end
            ST_E_READ: begin
                ahead_next  = (diff[ROUND_W-1] ? '0 : {1'b0, diff})
                            + {23'd0, weight_reg[flow_reg[1:0]]};
                sticky_next = flow_rd.sticky;
                state_next  = ST_E_CALC;
            end
            ST_E_CALC: begin
                if (ahead_reg >= {17'd0, burst_limit_reg}) begin
                    res_oc_next = OC_DROP_BURST;
                    state_next  = ST_DONE;
                end else begin
                    dep_next   = {1'b0, round_now_reg} + {17'd0, ahead_reg[BURST_W-1:0]};
                    state_next = ST_E_LEVEL;
                end
            end
            ST_E_LEVEL: begin
                if (lvl_hi && (dlt1 > 25'd1)) begin
                    res_oc_next = OC_DROP_LEVEL;
                    state_next  = ST_DONE;
                end else begin
                    level_next = lvl_pick;
                    slot_next  = {lvl_pick, bank_pick, idx_pick};
                    meta_re    = 1'b1;
                    meta_raddr = {lvl_pick, bank_pick, idx_pick};
                    state_next = ST_E_COMMIT;
                end
            end
            ST_E_COMMIT: begin
                if (meta_rd.fill[FILL_W-1]) begin
                    res_oc_next = OC_DROP_FULL;
                end else begin
                    store_we    = 1'b1;
                    meta_we     = 1'b1;
                    meta_wdata  = '{fill: meta_rd.fill + FILL_W'(1), head: meta_rd.head};
                    flow_we     = 1'b1;
                    held_next   = held_reg + HELD_W'(1);
                    res_oc_next = OC_STORED;
                end
                state_next = ST_DONE;
            end
            ST_D_START: begin
                if (held_reg == '0) begin
                    res_oc_next = OC_EMPTY;
                    state_next  = ST_DONE;
                end else if (rel_count_reg != '0) begin
                    rel_re     = 1'b1;
                    state_next = ST_POP;
                end else begin
                    rounds_next = '0;
                    phase_next  = PH_TOP;
                    slot_next   = {2'b10, round_now_reg[7:4]};
                    div_next    = FILL_W'(16) - {1'b0, round_now_reg[3:0]};
                    meta_re     = 1'b1;
                    meta_raddr  = {2'b10, round_now_reg[7:4]};
                    state_next  = ST_META;
                end
            end
            ST_META: begin
                fill_next  = meta_rd.fill;
                head_next  = meta_rd.head;
                acc_next   = '0;
                take_next  = '0;
                state_next = ST_SERVE;
            end
            ST_SERVE: begin
                // land the tag read last cycle
                if (pend_reg) begin
                    if (rel_count_reg < REL_CNT_W'(REL_DEPTH)) begin
                        rel_we         = 1'b1;
                        rel_tail_next  = rel_tail_reg + REL_AW'(1);
                        rel_count_next = rel_count_reg + REL_CNT_W'(1);
                    end else if (held_reg != '0) begin
                        held_next = held_reg - HELD_W'(1);
                    end
                end
                // ceiling share: keep taking while acc is below the fill
                if (acc_reg < fill_reg) begin
                    store_re  = 1'b1;
                    take_next = take_reg + FILL_W'(1);
                    acc_next  = acc_reg + div_reg;
                    pend_next = 1'b1;
                end else begin
                    meta_we = 1'b1;
                    if (phase_reg == PH_TOP) begin
                        phase_next = PH_LOW;
                        slot_next  = {1'b0, round_now_reg[4:0]};
                        div_next   = FILL_W'(1);
                        meta_re    = 1'b1;
                        meta_raddr = {1'b0, round_now_reg[4:0]};
                        state_next = ST_META;
                    end else begin
                        state_next = ST_RND_END;
                    end
                end
            end
            ST_RND_END: begin
                if (rel_count_reg != '0) begin
                    rel_re     = 1'b1;
                    state_next = ST_POP;
                end else begin
                    round_now_next = round_inc;
                    if (rounds_reg == '1) begin
                        res_oc_next = OC_EMPTY;
                        state_next  = ST_DONE;
                    end else begin
                        rounds_next = rounds_reg + ROUNDS_W'(1);
                        phase_next  = PH_TOP;
                        slot_next   = {2'b10, round_inc[7:4]};
                        div_next    = FILL_W'(16) - {1'b0, round_inc[3:0]};
                        meta_re     = 1'b1;
                        meta_raddr  = {2'b10, round_inc[7:4]};
                        state_next  = ST_META;
                    end
                end
            end
            ST_POP: begin
                res_tag_next   = rel_rdata;
                res_oc_next    = OC_DEQUEUED;
                rel_head_next  = rel_head_reg + REL_AW'(1);
                rel_count_next = rel_count_reg - REL_CNT_W'(1);
                if (held_reg != '0) begin
                    held_next = held_reg - HELD_W'(1);
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_oc_next     = res_oc_reg;
                    m_tag_next    = res_tag_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            round_now_reg   <= '0;
            held_reg        <= '0;
            rel_head_reg    <= '0;
            rel_tail_reg    <= '0;
            rel_count_reg   <= '0;
            pend_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            flow_vld_reg    <= '0;
            meta_vld_reg    <= '0;
            flow_rd_vld_reg <= 1'b0;
            meta_rd_vld_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_now_reg <= round_now_next;
            held_reg      <= held_next;
            rel_head_reg  <= rel_head_next;
            rel_tail_reg  <= rel_tail_next;
            rel_count_reg <= rel_count_next;
            pend_reg      <= pend_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (flow_we) begin
                flow_vld_reg[flow_reg] <= 1'b1;
            end
            if (meta_we) begin
                meta_vld_reg[meta_waddr] <= 1'b1;
            end
            if (flow_re) begin
                flow_rd_vld_reg <= flow_vld_reg[flow_raddr];
            end
            if (meta_re) begin
                meta_rd_vld_reg <= meta_vld_reg[meta_raddr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        flow_reg    <= flow_next;
        tag_reg     <= tag_next;
        ahead_reg   <= ahead_next;
        dep_reg     <= dep_next;
        sticky_reg  <= sticky_next;
        level_reg   <= level_next;
        slot_reg    <= slot_next;
        phase_reg   <= phase_next;
        fill_reg    <= fill_next;
        head_reg    <= head_next;
        acc_reg     <= acc_next;
        take_reg    <= take_next;
        div_reg     <= div_next;
        rounds_reg  <= rounds_next;
        res_oc_reg  <= res_oc_next;
        res_tag_reg <= res_tag_next;
        m_oc_reg    <= m_oc_next;
        m_tag_reg   <= m_tag_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tag_reg;
    assign m_tuser  = m_oc_reg;

`ifndef SYNTHESIS
    a_rel_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rel_count_reg <= REL_CNT_W'(REL_DEPTH))
        else $error("release list count out of range");

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= HELD_W'(HELD_MAX))
        else $error("held packet count out of range");

    a_take_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SERVE) |-> (take_reg <= fill_reg))
        else $error("slot serve took more than the fill");

    a_tag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_oc_reg != OC_DEQUEUED)) |-> (m_tag_reg == '0))
        else $error("released tag set on a non-dequeue result");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |-> (rel_count_reg != '0))
        else $error("pop from an empty release list");
`endif

endmodule

### tb/sv/calendar_checker.sv
`timescale 1ns / 1ps
module calendar_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          outstanding
);
    import hcs_pkg::*;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [TAG_W-1:0]     tag;
    } sched_result_t;

    sched_result_t  result_q[$];
    logic [TAG_W-1:0] release_q[$];

    logic [BURST_W-1:0]  burst_limit;
    weight_t             weight_tab [4];
    logic [ROUND_W-1:0]  round_now;
    logic [ROUND_W-1:0]  flow_last  [FLOW_COUNT];
    logic                flow_sticky[FLOW_COUNT];
    logic [TAG_W-1:0]    slot_mem   [SLOT_COUNT][16];
    int                  slot_fill  [SLOT_COUNT];
    int                  held_total;

    assign outstanding = result_q.size();

    task automatic serve_slot(input int lvl, input int bank);
        longint unsigned p, cur, divider, share;
        int idx, s, fill, take, i;
        p = (lvl == 0) ? 1 : 16;
        cur = round_now;
        idx = int'((cur / p) % 16);
        divider = p - cur % p;
        s = (lvl * 2 + bank) * 16 + idx;
        fill = slot_fill[s];
        share = (fill + divider - 1) / divider;
        take = (share < fill) ? int'(share) : fill;
        for (i = 0; i < take; i++) begin
            if (release_q.size() < REL_DEPTH) release_q = {release_q, slot_mem[s][i]};
            else if (held_total > 0) held_total--;
        end
        for (i = 0; i < fill - take; i++) slot_mem[s][i] = slot_mem[s][i + take];
        slot_fill[s] = fill - take;
    endtask

    function automatic logic [OUTCOME_W-1:0] place_packet(input int f,
                                                           input logic [TAG_W-1:0] tag);
        logic [ROUND_W-1:0] diff;
        longint unsigned ahead, dep, d, c;
        int lvl, bank, idx, s;
        diff = flow_last[f] - round_now;
        ahead = (diff < 32'h8000_0000) ? diff : 0;
        ahead += weight_tab[f % 4];
        if (ahead >= burst_limit) return OC_DROP_BURST;
        dep = longint'(round_now) + ahead;
        d = dep;
        c = round_now;
        lvl = 0;
        while (d / 16 - c / 16 > 1) begin
            lvl++;
            if (lvl >= 2) break;
            d /= 16;
            c /= 16;
        end
        if (lvl >= 2) return OC_DROP_LEVEL;
        bank = int'((d / 16) % 2);
        idx = int'(d % 16);
        if (flow_sticky[f] > lvl) lvl = 1;   // a flow never goes back down
        if (lvl == 1) bank = 0;
        s = (lvl * 2 + bank) * 16 + idx;
        if (slot_fill[s] >= 16) return OC_DROP_FULL;
        flow_last[f] = dep[31:0];
        flow_sticky[f] = (lvl == 1);
        slot_mem[s][slot_fill[s]] = tag;
        slot_fill[s]++;
        held_total++;
        return OC_STORED;
    endfunction

    task automatic predict_result(input logic mode, input int f,
                                  input logic [TAG_W-1:0] tag);
        sched_result_t r;
        int n;
        r.tag = '0;
        if (mode == MODE_ENQ) begin
            r.outcome = place_packet(f, tag);
        end else if (held_total == 0) begin
            r.outcome = OC_EMPTY;
        end else begin
            if (release_q.size() == 0) begin
                for (n = 0; n < 1024; n++) begin
                    serve_slot(1, 0);
                    serve_slot(0, int'((round_now / 16) % 2));
                    if (release_q.size() > 0) break;
                    round_now++;
                end
            end
            if (release_q.size() == 0) begin
                r.outcome = OC_EMPTY;
            end else begin
                r.outcome = OC_DEQUEUED;
                r.tag = release_q[0];
                release_q.delete(0);
                if (held_total > 0) held_total--;
            end
        end
        result_q = {result_q, r};
    endtask

    always @(posedge aclk) begin
        sched_result_t want;
        if (!aresetn) begin
            burst_limit = 16'd64;
            weight_tab[0] = 10'd1;
            weight_tab[1] = 10'd2;
            weight_tab[2] = 10'd4;
            weight_tab[3] = 10'd8;
            round_now = '0;
            held_total = 0;
            for (int i = 0; i < FLOW_COUNT; i++) begin
                flow_last[i] = '0;
                flow_sticky[i] = 1'b0;
            end
            for (int i = 0; i < SLOT_COUNT; i++) slot_fill[i] = 0;
            release_q.delete();
            result_q.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_BURST: burst_limit = pwdata[BURST_W-1:0];
                    REG_W0:    weight_tab[0] = pwdata[WEIGHT_W-1:0];
                    REG_W1:    weight_tab[1] = pwdata[WEIGHT_W-1:0];
                    REG_W2:    weight_tab[2] = pwdata[WEIGHT_W-1:0];
                    REG_W3:    weight_tab[3] = pwdata[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_result(s_tuser[0], int'(s_tdata[5:0]), s_tdata[21:6]);
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: outcome %0d tag %h", m_tuser, m_tdata);
                end else begin
                    want = result_q[0];
                    result_q.delete(0);
                    if (want.outcome !== m_tuser || want.tag !== m_tdata) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected outcome %0d tag %h, got %0d tag %h",
                                     want.outcome, want.tag, m_tuser, m_tdata);
                    end
                end
            end
        end
    end

endmodule

### tb/sv/hierarchical_calendar_scheduler_tb.sv
`timescale 1ns / 1ps
module hierarchical_calendar_scheduler_tb;
    import hcs_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [5:0] flow_number, [21:6] packet_tag
    logic [0:0]  s_tuser;    // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [15:0] released_tag
    logic [2:0]  m_tuser;    // [2:0] outcome
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;
    bit sink_quiet;          // no receiver stalls while set
    int stall_left;

    hierarchical_calendar_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    calendar_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop; real runs finish far earlier
    initial begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn || sink_quiet) begin
            m_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(3) == 0) stall_left <= gap_len();
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);    // register takes the value here
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one input transfer; valid stays high across back-to-back items
    task automatic send_item(input logic mode, input logic [5:0] flow,
                             input logic [15:0] tag, input bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, tag, flow};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic enq(input logic [5:0] flow, input logic [15:0] tag);
        send_item(MODE_ENQ, flow, tag, 1'b0);
    endtask

    task automatic deq();
        send_item(~MODE_ENQ, 6'd0, 16'($urandom), 1'b0);
    endtask

    // lets every result drain, then waits for the block to settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_weights(input int w0, input int w1, input int w2, input int w3);
        reg_write(REG_W0, w0);
        reg_write(REG_W1, w1);
        reg_write(REG_W2, w2);
        reg_write(REG_W3, w3);
    endtask

    task automatic random_phase(input int items, input int enq_pct);
        bit back2back;
        for (int i = 0; i < items; i++) begin
            back2back = (i % 64) < 16;    // a stretch with no sender gaps
            if ($urandom_range(99) < enq_pct)
                send_item(MODE_ENQ, 6'($urandom), 16'($urandom), back2back);
            else
                send_item(~MODE_ENQ, 6'($urandom), 16'($urandom), back2back);
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        m_tready   = 1'b1;
        sink_quiet = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty dequeue, field extremes under reset settings
        deq();
        enq(6'd0, 16'h0000);
        enq(6'd63, 16'hffff);
        enq(6'd2, 16'h5a5a);
        enq(6'd3, 16'ha5a5);
        repeat (5) deq();
        drain();

        // equal weights: seventeen flows aim at one slot, the last one overflows it
        set_weights(1, 1, 1, 1);
        for (int f = 0; f < 17; f++) enq(f[5:0], 16'(16'h1000 + f));
        drain();

        // burst limit at its floor drops everything
        reg_write(REG_BURST, 1);
        enq(6'd5, 16'h0bad);
        drain();
        // wide window with a heavy weight: too far ahead for the top level
        reg_write(REG_BURST, 16'hffff);
        set_weights(1023, 40, 1, 1);
        enq(6'd0, 16'h0c0c);
        enq(6'd1, 16'h0d0d);    // lands on the upper level, sticks there
        enq(6'd1, 16'h0e0e);
        drain();
        reg_write(REG_W1, 1);
        enq(6'd1, 16'h0f0f);    // small step, still upper level
        repeat (4) deq();
        drain();

        // random phases across several register settings
        random_phase(210, 55);
        drain();

        reg_write(REG_BURST, $urandom_range(1, 600));
        set_weights($urandom_range(1, 40), $urandom_range(1, 40),
                    $urandom_range(1, 40), $urandom_range(1, 40));
        random_phase(210, 60);
        drain();

        sink_quiet = 1'b1;
        reg_write(REG_BURST, 300);
        set_weights(1, 1, 16, 100);
        random_phase(210, 55);
        drain();

        sink_quiet = 1'b0;
        reg_write(REG_BURST, $urandom_range(1, 65535));
        set_weights($urandom_range(1, 1023), $urandom_range(1, 1023),
                    $urandom_range(1, 1023), $urandom_range(1, 1023));
        random_phase(200, 55);
        drain();

        repeat (50) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
